// File: rtl/core/page_bitmap_allocator_macros.svh
// assertion macros for the page bitmap allocator
// no dependencies
`ifndef PAGE_BITMAP_ALLOCATOR_MACROS_SVH
`define PAGE_BITMAP_ALLOCATOR_MACROS_SVH
`ifndef SYNTHESIS
`define PBA_ASSERT_IMP(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("pba");
`define PBA_ASSERT_NXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("pba");
`else
`define PBA_ASSERT_IMP(label, clk, rst, a, c)
`define PBA_ASSERT_NXT(label, clk, rst, a, c)
`endif
`endif

// File: rtl/core/pba_pkg.sv
// types and constants of the page bitmap allocator
// used by the top level
`default_nettype none
package pba_pkg;
   localparam int NUM_PAGES = 65536;
   localparam int WORD_BITS = 64;
   localparam logic [1:0] FUNC_ALLOC   = 2'd0;
   localparam logic [1:0] FUNC_FREE    = 2'd1;
   localparam logic [1:0] FUNC_RELEASE = 2'd2;
   typedef enum logic [9:0] {
      ST_IDLE  = 10'b0000000001,
      ST_CHECK = 10'b0000000010,
      ST_POP   = 10'b0000000100,
      ST_POPW  = 10'b0000001000,
      ST_SRD   = 10'b0000010000,
      ST_SCAN  = 10'b0000100000,
      ST_FRD   = 10'b0001000000,
      ST_FBIT  = 10'b0010000000,
      ST_INIT  = 10'b0100000000,
      ST_OUT   = 10'b1000000000
   } state_type;
endpackage
`default_nettype wire

// File: rtl/core/page_bitmap_allocator.sv
// page bitmap allocator: bitmap ram, recent-page stack ram, sequencer
// alloc of one page pops the recent-page stack when it is not empty; otherwise the bitmap is searched word by word
// free/release walk the pages one at a time, read then modify/write; one word in flight at a time
// after reset a clearing pass sets every bitmap word to all ones
// no word is accepted during that pass; reset clears control state and counts
`default_nettype none
module page_bitmap_allocator #(
   parameter int CACHE_DEPTH = 1024,
   parameter int PAGE_BYTES  = 4096
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [63:0] csr_wdata,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_func,
   input  wire logic [16:0] req_page_count,
   input  wire logic [63:0] req_address,
   input  wire logic        req_higher_half,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [63:0]      rsp_result_address,
   output logic             rsp_status,
   output logic [16:0]      rsp_pages_free
);
`include "page_bitmap_allocator_macros.svh"
   localparam int MAP_WORDS = (pba_pkg::NUM_PAGES + 63) / 64;
   localparam int MW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int CW = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
   localparam int PW = $clog2(pba_pkg::NUM_PAGES + 1);
   localparam int OB = $clog2(PAGE_BYTES);
   localparam int LASTW = pba_pkg::NUM_PAGES - (MAP_WORDS - 1) * 64;

   pba_pkg::state_type state_ff, state_in;
   logic [63:0] off_ff;
   logic [16:0] free_ff, free_in;
   logic [CW:0] rc_ff, rc_in;
   logic [1:0]  func_ff, func_in;
   logic [16:0] cnt_ff, cnt_in;
   logic [63:0] addr_ff, addr_in;
   logic        hh_ff, hh_in;
   logic [MW:0] widx_ff, widx_in;
   logic [PW-1:0] page_ff, page_in;
   logic [16:0] left_ff, left_in;
   logic [63:0] res_ff, res_in;
   logic        st_ff, st_in;
   logic        ov_ff, ov_in;

   logic          mw_en;
   logic [MW-1:0] mw_addr, mr_addr;
   logic [63:0]   mw_data, mr_data;
   logic          cw_en;
   logic [CW-1:0] cw_addr, cr_addr;
   logic [15:0]   cw_data, cr_data;

   pba_ram #(.WIDTH(64), .DEPTH(MAP_WORDS)) u_map (
      .clock, .wr_en(mw_en), .wr_addr(mw_addr), .wr_data(mw_data),
      .rd_addr(mr_addr), .rd_data(mr_data));
   pba_ram #(.WIDTH(16), .DEPTH(CACHE_DEPTH)) u_cache (
      .clock, .wr_en(cw_en), .wr_addr(cw_addr), .wr_data(cw_data),
      .rd_addr(cr_addr), .rd_data(cr_data));

   // run search over one word, lowest free window wins
   logic [63:0] wmask, found_mask, run_mask;
   logic [5:0]  found_pos;
   logic        found;
   always_comb begin
      wmask = mr_data;
      if (widx_ff[MW-1:0] == MW'(MAP_WORDS - 1) && LASTW < 64)
         wmask = mr_data | ~((64'd1 << LASTW) - 64'd1);
      run_mask = (cnt_ff[6:0] == 7'd64) ? {64{1'b1}}
               : ((64'd1 << cnt_ff[6:0]) - 64'd1);
      found = 1'b0;
      found_pos = 6'd0;
      for (int p = 63; p >= 0; p--) begin
         if (7'(p) + cnt_ff[6:0] <= 7'd64 && (wmask & (run_mask << p)) == 64'd0) begin
            found = 1'b1;
            found_pos = 6'(p);
         end
      end
      found_mask = run_mask << found_pos;
   end

   logic [63:0] stripped;
   logic [63:0] start_pg;
   logic [5:0]  bit_pos;
   assign stripped = (addr_ff >= off_ff) ? addr_ff - off_ff : addr_ff;
   assign start_pg = addr_ff >> OB;
   assign bit_pos  = page_ff[5:0];

   assign req_ready = (state_ff == pba_pkg::ST_IDLE) && !ov_ff;
   assign rsp_valid = ov_ff;
   assign rsp_result_address = res_ff;
   assign rsp_status = st_ff;
   assign rsp_pages_free = free_ff;

   always_comb begin
      state_in = state_ff; free_in = free_ff; rc_in = rc_ff;
      func_in = func_ff; cnt_in = cnt_ff; addr_in = addr_ff; hh_in = hh_ff;
      widx_in = widx_ff; page_in = page_ff; left_in = left_ff;
      res_in = res_ff; st_in = st_ff; ov_in = ov_ff;
      mw_en = 1'b0; mw_addr = widx_ff[MW-1:0]; mw_data = mr_data;
      mr_addr = widx_ff[MW-1:0];
      cw_en = 1'b0; cw_addr = rc_ff[CW-1:0]; cw_data = 16'(page_ff);
      cr_addr = CW'(rc_ff - 1'b1);
      if (ov_ff && rsp_ready) ov_in = 1'b0;
      case (state_ff)
         pba_pkg::ST_INIT: begin
            mw_en = 1'b1; mw_data = {64{1'b1}};
            widx_in = widx_ff + 1'b1;
            if (widx_ff == (MW+1)'(MAP_WORDS - 1)) state_in = pba_pkg::ST_IDLE;
         end
         pba_pkg::ST_IDLE: begin
            if (req_valid && req_ready) begin
               func_in = req_func; cnt_in = req_page_count;
               addr_in = req_address; hh_in = req_higher_half;
               state_in = pba_pkg::ST_CHECK;
            end
         end
         pba_pkg::ST_CHECK: begin
            res_in = 64'd0; st_in = 1'b1; state_in = pba_pkg::ST_OUT;
            widx_in = '0;
            if (func_ff == pba_pkg::FUNC_ALLOC) begin
               if (cnt_ff != 17'd0 && cnt_ff <= free_ff) begin
                  if (cnt_ff == 17'd1 && rc_ff != '0) state_in = pba_pkg::ST_POP;
                  else if (cnt_ff <= 17'd64) state_in = pba_pkg::ST_SRD;
               end
            end else if (func_ff == pba_pkg::FUNC_FREE
                         || func_ff == pba_pkg::FUNC_RELEASE) begin
               if (addr_ff[OB-1:0] == '0
                   && !(func_ff == pba_pkg::FUNC_FREE && addr_ff == 64'd0)) begin
                  if (func_ff == pba_pkg::FUNC_FREE) addr_in = stripped;
                  state_in = pba_pkg::ST_FRD;
               end
            end
         end
         pba_pkg::ST_POP: begin
            rc_in = rc_ff - 1'b1;
            state_in = pba_pkg::ST_POPW;
            widx_in = '0;
         end
         pba_pkg::ST_POPW: begin
            // cache ram data valid here; read map word next
            if (widx_ff == '0) begin
               page_in = PW'(cr_data);
               mr_addr = MW'(cr_data >> 6);
               widx_in = (MW+1)'(cr_data >> 6) | (MW+1)'(1) << MW;
            end else begin
               mw_en = (32'(page_ff) < pba_pkg::NUM_PAGES);
               mw_addr = widx_ff[MW-1:0];
               mw_data = mr_data | (64'd1 << bit_pos);
               free_in = free_ff - 17'd1;
               res_in = (64'(page_ff) << OB) + (hh_ff ? off_ff : 64'd0);
               st_in = 1'b0;
               state_in = pba_pkg::ST_OUT;
            end
         end
         pba_pkg::ST_SRD: begin
            state_in = pba_pkg::ST_SCAN;
         end
         pba_pkg::ST_SCAN: begin
            if (found) begin
               mw_en = 1'b1;
               mw_data = mr_data | found_mask;
               free_in = free_ff - cnt_ff;
               res_in = ((64'(widx_ff[MW-1:0]) * 64 + 64'(found_pos)) << OB)
                        + (hh_ff ? off_ff : 64'd0);
               st_in = 1'b0;
               state_in = pba_pkg::ST_OUT;
            end else if (widx_ff == (MW+1)'(MAP_WORDS - 1)) begin
               state_in = pba_pkg::ST_OUT;
            end else begin
               widx_in = widx_ff + 1'b1;
               state_in = pba_pkg::ST_SRD;
            end
         end
         pba_pkg::ST_FRD: begin
            if (start_pg > 64'(pba_pkg::NUM_PAGES)
                || 64'(cnt_ff) > 64'(pba_pkg::NUM_PAGES) - start_pg) begin
               state_in = pba_pkg::ST_OUT;
            end else if (cnt_ff == 17'd0) begin
               st_in = 1'b0; state_in = pba_pkg::ST_OUT;
            end else begin
               page_in = PW'(start_pg);
               left_in = cnt_ff;
               widx_in = (MW+1)'(start_pg >> 6);
               state_in = pba_pkg::ST_FBIT;
            end
         end
         pba_pkg::ST_FBIT: begin
            // each page is read, then modified and written back
            if (widx_ff[MW]) begin
               widx_in[MW] = 1'b0;
               if (mr_data[bit_pos]) begin
                  mw_en = 1'b1;
                  mw_data = mr_data & ~(64'd1 << bit_pos);
                  free_in = free_ff + 17'd1;
                  if (func_ff == pba_pkg::FUNC_FREE && cnt_ff == 17'd1
                      && rc_ff < (CW+1)'(CACHE_DEPTH)) begin
                     cw_en = 1'b1;
                     rc_in = rc_ff + 1'b1;
                  end
               end
               left_in = left_ff - 17'd1;
               page_in = page_ff + 1'b1;
               if (left_ff == 17'd1) begin
                  st_in = 1'b0; state_in = pba_pkg::ST_OUT;
               end
            end else begin
               mr_addr = MW'(page_ff >> 6);
               widx_in = {1'b1, MW'(page_ff >> 6)};
            end
         end
         pba_pkg::ST_OUT: begin
            if (!ov_ff || rsp_ready) begin
               ov_in = 1'b1;
               state_in = pba_pkg::ST_IDLE;
            end
         end
         default: state_in = pba_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pba_pkg::ST_INIT;
         off_ff <= 64'd0; free_ff <= 17'd0; rc_ff <= '0;
         widx_ff <= '0; ov_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         off_ff <= csr_we ? csr_wdata : off_ff;
         free_ff <= free_in; rc_ff <= rc_in;
         widx_ff <= widx_in; ov_ff <= ov_in;
      end
      func_ff <= func_in; cnt_ff <= cnt_in; addr_ff <= addr_in; hh_ff <= hh_in;
      page_ff <= page_in; left_ff <= left_in; res_ff <= res_in; st_ff <= st_in;
   end

   `PBA_ASSERT_IMP(a_fail_zero, clock, reset, rsp_valid && rsp_status, rsp_result_address == 64'd0)
   `PBA_ASSERT_IMP(a_rc_bound, clock, reset, 1'b1, rc_ff <= (CW+1)'(CACHE_DEPTH))
   `PBA_ASSERT_IMP(a_free_bound, clock, reset, 1'b1, 32'(free_ff) <= pba_pkg::NUM_PAGES)
   `PBA_ASSERT_NXT(a_push_grow, clock, reset, cw_en, rc_ff == $past(rc_ff) + 1'b1)
endmodule
`default_nettype wire

// File: rtl/core/pba_ram.sv
// generic single-port-write, single-read ram with registered read
// no dependencies
`default_nettype none
module pba_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire
